FILE: src/afbt_pkg.sv
// Shared types and constants for the address-sorted free-block table.
`timescale 1ns / 1ps
package afbt_pkg;
    localparam int unsigned AddrW = 32;
    localparam int unsigned SizeW = 32;

    typedef enum logic [2:0] {
        OP_INSERT  = 3'd0,
        OP_TAKE    = 3'd1,
        OP_REMOVE  = 3'd2,
        OP_LOOKUP  = 3'd3,
        OP_PAIRS   = 3'd4,
        OP_PARTNER = 3'd5,
        OP_CLEAR   = 3'd6,
        OP_NOP     = 3'd7
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_RSVD     = 2'd3
    } status_t;

    typedef struct packed {
        logic [AddrW-1:0] addr;
        logic [SizeW-1:0] size;
    } entry_t;
endpackage

FILE: src/afbt_cell.sv
// One table cell: holds one entry and takes its neighbor's entry on each shift.
`timescale 1ns / 1ps
module afbt_cell (
    input  logic              aclk,
    input  logic              shift_en,
    input  afbt_pkg::entry_t  entry_in,
    output afbt_pkg::entry_t  entry_out
);
    afbt_pkg::entry_t entry_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            entry_reg <= entry_in;
        end
    end

    assign entry_out = entry_reg;
endmodule

FILE: src/address_sorted_free_block_table_core.sv
// Top level of the address-sorted free-block table: a rotating ring of entry cells.
`timescale 1ns / 1ps
// The table is a ring of TABLE_DEPTH cells that rotates by one entry per cycle while an
// operation runs; a sequencer watches the two head cells and rewrites the stream fed back
// into the tail, which inserts, deletes or scans entries in one full turn. Insert, take lowest,
// remove, lookup, count pairs and pair partner each rotate the ring through one full turn;
// clear, the unused opcode and an insert into a full table skip the rotation. One item is in
// work at a time, and its result beat waits in an output register until taken.
module address_sorted_free_block_table_core #(
    parameter int unsigned TABLE_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_opcode,
    input  logic [31:0] s_block_address,
    input  logic [31:0] s_block_size,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_result_address,
    output logic [31:0] m_result_size,
    output logic [4:0]  m_pair_count,
    output logic [5:0]  m_entries_held
);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned PW = $clog2(TABLE_DEPTH / 2 + 1);
    localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] LastC  = CW'(TABLE_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] step_reg, step_next;
    afbt_pkg::opcode_t op_reg, op_next;
    logic [31:0] key_reg, key_next, nsize_reg, nsize_next;
    logic done_reg, done_next;
    logic found_reg, found_next;
    logic skip_reg, skip_next;
    logic [PW-1:0] pairs_reg, pairs_next;
    afbt_pkg::entry_t held_reg, held_next, prev_reg, prev_next;
    logic [31:0] raddr_reg, raddr_next, rsize_reg, rsize_next;
    afbt_pkg::status_t stat_reg, stat_next;

    logic m_valid_reg;
    logic [1:0] m_status_reg;
    logic [31:0] m_raddr_reg, m_rsize_reg;
    logic [4:0] m_pairs_reg;
    logic [5:0] m_held_reg;

    afbt_pkg::entry_t ring [TABLE_DEPTH];
    afbt_pkg::entry_t emit;
    logic shift_en;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        afbt_cell u_cell (
            .aclk     (aclk),
            .shift_en (shift_en),
            .entry_in ((g == TABLE_DEPTH - 1) ? emit : ring[(g + 1) % TABLE_DEPTH]),
            .entry_out(ring[g])
        );
    end

    afbt_pkg::entry_t head, second;
    logic in_range, next_in_range, head_hit, next_adj, prev_adj, out_free;
    assign head   = ring[0];
    assign second = ring[1];
    assign in_range      = step_reg < cnt_reg;
    assign next_in_range = (step_reg + CW'(1)) < cnt_reg;
    assign head_hit = head.addr == key_reg;
    assign next_adj = (second.addr - head.addr) == head.size;
    assign prev_adj = (head.addr - prev_reg.addr) == prev_reg.size;
    assign shift_en = state_reg == S_RUN;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = state_reg == S_IDLE;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        step_next  = step_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        nsize_next = nsize_reg;
        done_next  = done_reg;
        found_next = found_reg;
        skip_next  = skip_reg;
        pairs_next = pairs_reg;
        held_next  = held_reg;
        prev_next  = prev_reg;
        raddr_next = raddr_reg;
        rsize_next = rsize_reg;
        stat_next  = stat_reg;
        emit       = head;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = afbt_pkg::opcode_t'(s_opcode);
                    key_next   = s_block_address;
                    nsize_next = s_block_size;
                    step_next  = '0;
                    done_next  = 1'b0;
                    found_next = 1'b0;
                    skip_next  = 1'b0;
                    pairs_next = '0;
                    raddr_next = '0;
                    rsize_next = '0;
                    stat_next  = afbt_pkg::ST_OK;
                    state_next = S_RUN;
                    case (afbt_pkg::opcode_t'(s_opcode))
                        afbt_pkg::OP_INSERT: begin
                            if (cnt_reg >= DepthC) begin
                                stat_next  = afbt_pkg::ST_FULL;
                                state_next = S_FIN;
                            end
                        end
                        afbt_pkg::OP_CLEAR: begin
                            cnt_next   = '0;
                            state_next = S_FIN;
                        end
                        afbt_pkg::OP_NOP: state_next = S_FIN;
                        default: ;
                    endcase
                end
            end
            S_RUN: begin
                prev_next = head;
                case (op_reg)
                    afbt_pkg::OP_INSERT: begin
                        if (done_reg) begin
                            emit      = held_reg;
                            held_next = head;
                        end else if (!in_range || !(head.addr < key_reg)) begin
                            emit.addr = key_reg;
                            emit.size = nsize_reg;
                            held_next = head;
                            done_next = 1'b1;
                        end
                    end
                    afbt_pkg::OP_TAKE, afbt_pkg::OP_REMOVE: begin
                        if (done_reg) begin
                            emit = second;
                        end else if (in_range && (op_reg == afbt_pkg::OP_TAKE || head_hit)) begin
                            emit       = second;
                            done_next  = 1'b1;
                            found_next = 1'b1;
                            raddr_next = head.addr;
                            rsize_next = head.size;
                        end
                    end
                    afbt_pkg::OP_LOOKUP: begin
                        if (!done_reg && in_range && head_hit) begin
                            done_next  = 1'b1;
                            found_next = 1'b1;
                            rsize_next = head.size;
                        end
                    end
                    afbt_pkg::OP_PAIRS: begin
                        if (skip_reg) begin
                            skip_next = 1'b0;
                        end else if (next_in_range && next_adj) begin
                            skip_next  = 1'b1;
                            pairs_next = pairs_reg + PW'(1);
                        end
                    end
                    afbt_pkg::OP_PARTNER: begin
                        if (!done_reg && in_range && head_hit) begin
                            if (next_in_range && next_adj) begin
                                done_next  = 1'b1;
                                found_next = 1'b1;
                                raddr_next = second.addr;
                            end else if (step_reg != '0 && prev_adj) begin
                                done_next  = 1'b1;
                                found_next = 1'b1;
                                raddr_next = prev_reg.addr;
                            end
                        end
                    end
                    default: ;
                endcase
                step_next = step_reg + CW'(1);
                if (step_reg == LastC) begin
                    state_next = S_FIN;
                    case (op_reg)
                        afbt_pkg::OP_INSERT: cnt_next = cnt_reg + CW'(1);
                        afbt_pkg::OP_TAKE, afbt_pkg::OP_REMOVE: begin
                            if (found_next) begin
                                cnt_next = cnt_reg - CW'(1);
                            end else begin
                                stat_next = afbt_pkg::ST_NOTFOUND;
                            end
                        end
                        afbt_pkg::OP_LOOKUP, afbt_pkg::OP_PARTNER: begin
                            if (!found_next) begin
                                stat_next = afbt_pkg::ST_NOTFOUND;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_FIN: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (state_reg == S_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        step_reg  <= step_next;
        op_reg    <= op_next;
        key_reg   <= key_next;
        nsize_reg <= nsize_next;
        done_reg  <= done_next;
        found_reg <= found_next;
        skip_reg  <= skip_next;
        pairs_reg <= pairs_next;
        held_reg  <= held_next;
        prev_reg  <= prev_next;
        raddr_reg <= raddr_next;
        rsize_reg <= rsize_next;
        stat_reg  <= stat_next;
        if (state_reg == S_FIN && out_free) begin
            m_status_reg <= stat_reg;
            m_raddr_reg  <= raddr_reg;
            m_rsize_reg  <= rsize_reg;
            m_pairs_reg  <= (32'(pairs_reg) > 32'd31) ? 5'd31 : 5'(pairs_reg);
            m_held_reg   <= (32'(cnt_reg) > 32'd63) ? 6'd63 : 6'(cnt_reg);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_result_address = m_raddr_reg;
    assign m_result_size    = m_rsize_reg;
    assign m_pair_count     = m_pairs_reg;
    assign m_entries_held   = m_held_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= DepthC) else $error("entry count above table depth");
    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RUN) |-> (step_reg <= LastC)) else $error("rotation overran");
    a_fin_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && out_free) |=> (m_valid && state_reg == S_IDLE))
        else $error("finished item did not produce a result beat");
    a_idle_no_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_RUN) |-> !shift_en) else $error("ring moved outside an operation");
endmodule
